[design/pme_pkg.sv]
// package for the polyline mitre extruder: payload types, widths and rounding helpers
// no dependencies; imported by every other file of the block
`default_nettype none
package pme_pkg;

    localparam int DATA_W         = 32;
    localparam int T_W            = 31;
    localparam int OUT_IDX_W      = 16;
    localparam int UNIT_SHIFT     = 30;
    localparam int VEC_W          = 34;
    localparam int MUL_A_W        = 34;
    localparam int MUL_B_W        = 32;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int RND_IN_W       = PROD_W + 2;
    localparam int RND_OUT_W      = RND_IN_W - UNIT_SHIFT;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 16;
    localparam int PADDR_W        = 3;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic                     end_of_line;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] upper_x;
        logic signed [DATA_W-1:0] upper_y;
        logic signed [DATA_W-1:0] lower_x;
        logic signed [DATA_W-1:0] lower_y;
        logic [OUT_IDX_W-1:0]     point_index;
        logic                     last_of_line;
        logic                     single_point_error;
    } t_out_item;

    // shift right by the unit shift, rounding to nearest with halves away from zero
    function automatic logic signed [RND_OUT_W-1:0] rnd_unit(input logic signed [RND_IN_W-1:0] v);
        logic [RND_IN_W-1:0]  mag;
        logic [RND_IN_W-1:0]  sum;
        logic [RND_OUT_W-1:0] m;
        mag = v[RND_IN_W-1] ? RND_IN_W'(-v) : RND_IN_W'(v);
        sum = mag + (RND_IN_W'(1) << (UNIT_SHIFT - 1));
        m   = sum[RND_IN_W-1:UNIT_SHIFT];
        return v[RND_IN_W-1] ? RND_OUT_W'(-$signed(m)) : $signed(m);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [RND_OUT_W:0] v);
        logic signed [RND_OUT_W:0] hi;
        logic signed [RND_OUT_W:0] lo;
        hi = (RND_OUT_W+1)'(2147483647);
        lo = -hi - (RND_OUT_W+1)'(1);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

endpackage
`default_nettype wire

[design/pme_if.sv]
// valid/ready stream interfaces for points in and vertex pairs out
// depends on pme_pkg for the payload structs
`default_nettype none
interface pme_in_if;
    import pme_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pme_out_if;
    import pme_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/pme_cfg.sv]
// apb register file: holds the offset scale line_half_width
// depends on pme_pkg for widths
`default_nettype none
module pme_cfg #(
    parameter int FRAC_BITS = pme_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pme_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [pme_pkg::T_W-1:0]     o_half_width
);
    import pme_pkg::*;

    localparam logic [T_W-1:0] RST_T = T_W'(1) << FRAC_BITS;
    localparam logic           REG_HALF_WIDTH = 1'b0;

    logic [T_W-1:0] r_half_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= RST_T;
        end else if (psel && penable && pwrite && (paddr[2] == REG_HALF_WIDTH)) begin
            r_half_width <= pwdata[T_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HALF_WIDTH) begin
            prdata = {1'b0, r_half_width};
        end
    end

    assign pready       = 1'b1;
    assign o_half_width = r_half_width;

endmodule
`default_nettype wire

[design/pme_norm.sv]
// iterative vector normaliser: range shift, squares, bit-serial square root
// and two restoring divisions, giving a q2.30 unit vector; depends on pme_pkg
`default_nettype none
module pme_norm (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [pme_pkg::VEC_W-1:0]  i_x,
    input  wire logic signed [pme_pkg::VEC_W-1:0]  i_y,
    output logic                                   o_done,
    output logic                                   o_good,
    output logic signed [pme_pkg::DATA_W-1:0]      o_ux,
    output logic signed [pme_pkg::DATA_W-1:0]      o_uy
);
    import pme_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQX   = 3'd2;
    localparam logic [2:0] N_SQY   = 3'd3;
    localparam logic [2:0] N_SQRT  = 3'd4;
    localparam logic [2:0] N_DSET  = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;
    localparam logic [2:0] N_FIN   = 3'd7;

    logic [2:0]       r_state;
    logic [4:0]       r_cnt;
    logic             r_sx, r_sy, r_good, r_ysel;
    logic [VEC_W-1:0] r_ax, r_ay;
    logic [63:0]      r_v, r_root, r_bit;
    logic [31:0]      r_mag, r_rem;
    logic [30:0]      r_num, r_q, r_qx;
    logic signed [DATA_W-1:0] r_ux, r_uy;

    logic [VEC_W-1:0] ax_in, ay_in, mx;
    logic [30:0]      sq_in, d_sel;
    logic [61:0]      sq, num0;
    logic [63:0]      trial;
    logic [32:0]      dtrial;
    logic             ge;
    logic [30:0]      q_next;

    always_comb begin
        ax_in  = i_x[VEC_W-1] ? VEC_W'(-i_x) : VEC_W'(i_x);
        ay_in  = i_y[VEC_W-1] ? VEC_W'(-i_y) : VEC_W'(i_y);
        mx     = (r_ax > r_ay) ? r_ax : r_ay;
        sq_in  = (r_state == N_SQX) ? r_ax[30:0] : r_ay[30:0];
        sq     = {31'b0, sq_in} * {31'b0, sq_in};
        trial  = r_root + r_bit;
        d_sel  = r_ysel ? r_ay[30:0] : r_ax[30:0];
        // numerator is the component in q2.30 plus half the magnitude
        num0   = {1'b0, d_sel, 30'b0} + 62'(r_root[31:1]);
        dtrial = {r_rem, r_num[30]};
        ge     = dtrial >= {1'b0, r_mag};
        q_next = {r_q[29:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_cnt   <= '0;
            r_good  <= 1'b0;
            r_ysel  <= 1'b0;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_ax   <= ax_in;
                        r_ay   <= ay_in;
                        r_sx   <= i_x[VEC_W-1];
                        r_sy   <= i_y[VEC_W-1];
                        r_ysel <= 1'b0;
                        r_ux   <= '0;
                        r_uy   <= '0;
                        if ((ax_in == '0) && (ay_in == '0)) begin
                            r_good  <= 1'b0;
                            r_state <= N_FIN;
                        end else begin
                            r_good  <= 1'b1;
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    // bring the larger component into [2^30, 2^31)
                    if (mx[VEC_W-1:31] != '0) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (mx[30:22] == '0) begin
                        r_ax <= r_ax << 8;
                        r_ay <= r_ay << 8;
                    end else if (!mx[30]) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_state <= N_SQX;
                    end
                end
                N_SQX: begin
                    r_v     <= {2'b0, sq};
                    r_state <= N_SQY;
                end
                N_SQY: begin
                    r_v     <= r_v + {2'b0, sq};
                    r_root  <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_cnt   <= '0;
                    r_state <= N_SQRT;
                end
                N_SQRT: begin
                    if (r_v >= trial) begin
                        r_v    <= r_v - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_mag   <= r_root[31:0];
                    r_rem   <= {1'b0, num0[61:31]};
                    r_num   <= num0[30:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_rem <= ge ? 32'(dtrial - {1'b0, r_mag}) : dtrial[31:0];
                    r_num <= r_num << 1;
                    r_q   <= q_next;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        if (!r_ysel) begin
                            r_qx    <= q_next;
                            r_ysel  <= 1'b1;
                            r_state <= N_DSET;
                        end else begin
                            r_ux    <= r_sx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
                            r_uy    <= r_sy ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
                            r_state <= N_FIN;
                        end
                    end
                end
                N_FIN: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == N_FIN);
    assign o_good = r_good;
    assign o_ux   = r_ux;
    assign o_uy   = r_uy;

endmodule
`default_nettype wire

[design/polyline_mitre_extruder.sv]
// Polyline mitre extruder. Points come in one transfer at a time and each point yields a
// pair of vertices, one point late; the final point of a line yields two results. Each
// result runs up to three vector normalisations through one shared normaliser (range
// shift, 32-step square root, two 31-step divisions) and eight steps on one shared 34x32
// multiplier; the input is not ready while a point is being worked on.
// Depends on pme_pkg, pme_if, pme_cfg and pme_norm.
`default_nettype none
module polyline_mitre_extruder #(
    parameter int FRAC_BITS  = pme_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = pme_pkg::INDEX_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    pme_in_if.sink                           i_in,
    pme_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pme_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import pme_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_N0   = 5'd1;
    localparam logic [4:0] S_W0   = 5'd2;
    localparam logic [4:0] S_N1   = 5'd3;
    localparam logic [4:0] S_W1   = 5'd4;
    localparam logic [4:0] S_N2   = 5'd5;
    localparam logic [4:0] S_W2   = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_M2   = 5'd8;
    localparam logic [4:0] S_M3   = 5'd9;
    localparam logic [4:0] S_M4   = 5'd10;
    localparam logic [4:0] S_M5   = 5'd11;
    localparam logic [4:0] S_M6   = 5'd12;
    localparam logic [4:0] S_M7   = 5'd13;
    localparam logic [4:0] S_M8   = 5'd14;
    localparam logic [4:0] S_OUT  = 5'd15;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    logic [T_W-1:0] half_width;

    pme_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_half_width (half_width)
    );

    logic [4:0]                r_state;
    logic [INDEX_BITS-1:0]     r_cnt, r_idx, r_idx2;
    logic signed [DATA_W-1:0]  r_held_x, r_held_y, r_bef_x, r_bef_y;
    logic signed [DATA_W-1:0]  r_px, r_py, r_in_x, r_in_y;
    logic signed [VEC_W-1:0]   r_d0x, r_d0y, r_d1x, r_d1y;
    logic signed [DATA_W-1:0]  r_u0x, r_u0y, r_u1x, r_u1y, r_mx, r_my;
    logic                      r_g0, r_second, r_last, r_err, r_ov;
    logic signed [PROD_W-1:0]  r_prod, r_p1;
    logic signed [MUL_A_W-1:0] r_dot, r_l;
    logic signed [RND_OUT_W-1:0] r_ox, r_oy;
    t_out_item                 r_out;

    logic                      acc, load, norm_start, norm_done, norm_good;
    logic signed [VEC_W-1:0]   norm_x, norm_y, in_d1x, in_d1y;
    logic signed [DATA_W-1:0]  norm_ux, norm_uy;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    t_out_item                 res;

    assign acc  = i_in.valid && i_in.ready;
    assign load = (r_state == S_OUT) && (!r_ov || o_out.ready);

    always_comb begin
        norm_start = (r_state == S_N0) || (r_state == S_N1) || (r_state == S_N2);
        norm_x = r_d0x;
        norm_y = r_d0y;
        if (r_state == S_N1) begin
            norm_x = r_d1x;
            norm_y = r_d1y;
        end else if (r_state == S_N2) begin
            norm_x = VEC_W'(r_u0x) + VEC_W'(r_u1x);
            norm_y = VEC_W'(r_u0y) + VEC_W'(r_u1y);
        end
        in_d1x = VEC_W'(i_in.data.point_x) - VEC_W'(r_held_x);
        in_d1y = VEC_W'(i_in.data.point_y) - VEC_W'(r_held_y);
    end

    pme_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_x     (norm_x),
        .i_y     (norm_y),
        .o_done  (norm_done),
        .o_good  (norm_good),
        .o_ux    (norm_ux),
        .o_uy    (norm_uy)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = MUL_A_W'(r_mx);
        mul_b = r_u1y;
        case (r_state)
            S_M2: begin
                mul_a = MUL_A_W'(r_my);
                mul_b = r_u1x;
            end
            S_M4: begin
                mul_a = r_dot;
                mul_b = $signed({1'b0, half_width});
            end
            S_M6: begin
                mul_a = r_l;
                mul_b = r_mx;
            end
            S_M7: begin
                mul_a = r_l;
                mul_b = r_my;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        res.upper_x            = sat_data((RND_OUT_W+1)'(r_px) + (RND_OUT_W+1)'(r_ox));
        res.upper_y            = sat_data((RND_OUT_W+1)'(r_py) + (RND_OUT_W+1)'(r_oy));
        res.lower_x            = sat_data((RND_OUT_W+1)'(r_px) - (RND_OUT_W+1)'(r_ox));
        res.lower_y            = sat_data((RND_OUT_W+1)'(r_py) - (RND_OUT_W+1)'(r_oy));
        res.point_index        = OUT_IDX_W'(r_idx);
        res.last_of_line       = r_last;
        res.single_point_error = 1'b0;
        if (r_err) begin
            res.upper_x            = '0;
            res.upper_y            = '0;
            res.lower_x            = '0;
            res.lower_y            = '0;
            res.point_index        = '0;
            res.last_of_line       = 1'b1;
            res.single_point_error = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_second <= 1'b0;
            r_ov     <= 1'b0;
            r_err    <= 1'b0;
            r_held_x <= '0;
            r_held_y <= '0;
            r_bef_x  <= '0;
            r_bef_y  <= '0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_out <= res;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (r_cnt == '0) begin
                            if (i_in.data.end_of_line) begin
                                r_err   <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_held_x <= i_in.data.point_x;
                                r_held_y <= i_in.data.point_y;
                                r_cnt    <= INDEX_BITS'(1);
                            end
                        end else begin
                            r_err    <= 1'b0;
                            r_px     <= r_held_x;
                            r_py     <= r_held_y;
                            r_in_x   <= i_in.data.point_x;
                            r_in_y   <= i_in.data.point_y;
                            r_d1x    <= in_d1x;
                            r_d1y    <= in_d1y;
                            if (r_cnt > INDEX_BITS'(1)) begin
                                r_d0x <= VEC_W'(r_held_x) - VEC_W'(r_bef_x);
                                r_d0y <= VEC_W'(r_held_y) - VEC_W'(r_bef_y);
                            end else begin
                                r_d0x <= in_d1x;
                                r_d0y <= in_d1y;
                            end
                            r_idx    <= r_cnt - INDEX_BITS'(1);
                            r_idx2   <= r_cnt;
                            r_last   <= 1'b0;
                            r_second <= i_in.data.end_of_line;
                            r_ox     <= '0;
                            r_oy     <= '0;
                            if (i_in.data.end_of_line) begin
                                r_cnt <= '0;
                            end else begin
                                r_bef_x  <= r_held_x;
                                r_bef_y  <= r_held_y;
                                r_held_x <= i_in.data.point_x;
                                r_held_y <= i_in.data.point_y;
                                if (r_cnt != IDX_MAX) begin
                                    r_cnt <= r_cnt + INDEX_BITS'(1);
                                end
                            end
                            r_state  <= S_N0;
                        end
                    end
                end
                S_N0: r_state <= S_W0;
                S_W0: begin
                    if (norm_done) begin
                        r_u0x   <= norm_ux;
                        r_u0y   <= norm_uy;
                        r_g0    <= norm_good;
                        r_state <= S_N1;
                    end
                end
                S_N1: r_state <= S_W1;
                S_W1: begin
                    if (norm_done) begin
                        r_u1x   <= norm_ux;
                        r_u1y   <= norm_uy;
                        // a zero-length segment leaves the offset at zero
                        r_state <= (r_g0 && norm_good) ? S_N2 : S_OUT;
                    end
                end
                S_N2: r_state <= S_W2;
                S_W2: begin
                    if (norm_done) begin
                        r_mx    <= norm_uy;
                        r_my    <= -norm_ux;
                        r_state <= norm_good ? S_M1 : S_OUT;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_p1    <= r_prod;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_dot   <= MUL_A_W'(rnd_unit(RND_IN_W'(r_p1) - RND_IN_W'(r_prod)));
                    r_state <= S_M4;
                end
                S_M4: r_state <= S_M5;
                S_M5: begin
                    r_l     <= MUL_A_W'(rnd_unit(RND_IN_W'(r_prod)));
                    r_state <= S_M6;
                end
                S_M6: r_state <= S_M7;
                S_M7: begin
                    r_ox    <= rnd_unit(RND_IN_W'(r_prod));
                    r_state <= S_M8;
                end
                S_M8: begin
                    r_oy    <= rnd_unit(RND_IN_W'(r_prod));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load) begin
                        if (r_second) begin
                            // final point: both directions are the last segment
                            r_second <= 1'b0;
                            r_px     <= r_in_x;
                            r_py     <= r_in_y;
                            r_d0x    <= r_d1x;
                            r_d0y    <= r_d1y;
                            r_idx    <= r_idx2;
                            r_last   <= 1'b1;
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_state  <= S_N0;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done |-> (r_state == S_W0 || r_state == S_W1 || r_state == S_W2))
        else $error("normaliser finished outside a wait state");

    a_second_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_second)
        else $error("pending final-point result lost");

    a_start_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_cnt != '0) |=> (r_state == S_N0))
        else $error("held point transfer did not start a result");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> ($stable(r_out) && r_ov))
        else $error("waiting result overwritten");

endmodule
`default_nettype wire
